>>> sv/led_clock_digit_serial_sender_top_assert.svh
// assertion macros for the led clock digit sender, included by the back part
`ifndef LED_CLOCK_DIGIT_SERIAL_SENDER_TOP_ASSERT_SVH
`define LED_CLOCK_DIGIT_SERIAL_SENDER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LCDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LCDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lcds_pkg.sv
// types, constants and segment table for the led clock digit sender
package lcds_pkg;

    // bus symbol codes
    localparam logic [1:0] SYM_START = 2'd0;
    localparam logic [1:0] SYM_BIT   = 2'd1;
    localparam logic [1:0] SYM_ACK   = 2'd2;
    localparam logic [1:0] SYM_STOP  = 2'd3;

    // configuration register indexes
    localparam logic CFG_BRIGHTNESS = 1'b0;
    localparam logic CFG_ENABLE     = 1'b1;

    // command bytes
    localparam logic [7:0] CMD_ADDR_FIXED = 8'h44;
    localparam logic [7:0] CMD_CELL_BASE  = 8'hC0;
    localparam logic [3:0] CMD_CTL_HIGH   = 4'h8;

    // symbol positions inside the 42-symbol run
    localparam logic [5:0] F1_START  = 6'd0;
    localparam logic [5:0] B_ADDR    = 6'd1;
    localparam logic [5:0] F1_ACK    = 6'd9;
    localparam logic [5:0] F1_STOP   = 6'd10;
    localparam logic [5:0] F2_START  = 6'd11;
    localparam logic [5:0] B_CELL    = 6'd12;
    localparam logic [5:0] F2_ACK1   = 6'd20;
    localparam logic [5:0] B_SEG     = 6'd21;
    localparam logic [5:0] F2_ACK2   = 6'd29;
    localparam logic [5:0] F2_STOP   = 6'd30;
    localparam logic [5:0] F3_START  = 6'd31;
    localparam logic [5:0] B_CTL     = 6'd32;
    localparam logic [5:0] F3_ACK    = 6'd40;
    localparam logic [5:0] STEP_LAST = 6'd41;

    // queue between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [7:0] seg;
        logic [1:0] slot;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_q_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

    // 7-segment pattern of a decimal digit
    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            default: seg = 7'h6F;
        endcase
        return seg;
    endfunction

endpackage

>>> sv/lcds_front.sv
// front part: drops cells out of range, picks the digit and builds its segment byte
module lcds_front import lcds_pkg::*; #(
    parameter int CELL_COUNT = 4
) (
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_cell_index,
    input  logic [4:0] i_hour_value,
    input  logic [5:0] i_minute_value,
    input  logic       i_colon_on,
    output t_q_push    o_q_push
);

    logic [5:0] value;
    logic [9:0] prod;
    logic [2:0] tens;
    logic [5:0] units;
    logic [3:0] digit;
    logic       in_range;

    // cells 0/1 take hours, 2/3 minutes
    assign value    = i_cell_index[1] ? i_minute_value : {1'b0, i_hour_value};
    // divide by ten via reciprocal, exact for values below 64
    assign prod     = {4'b0, value} * 10'd13;
    assign tens     = prod[9:7];
    assign units    = value - ({3'b0, tens} * 6'd10);
    assign digit    = i_cell_index[0] ? units[3:0] : {1'b0, tens};
    assign in_range = int'(i_cell_index) < CELL_COUNT;

    assign o_q_push.push       = i_push && !i_full && in_range;
    assign o_q_push.entry.seg  = {i_colon_on, seg_of(digit)};
    assign o_q_push.entry.slot = i_cell_index;

endmodule

>>> sv/lcds_queue.sv
// two-entry queue between the front and the back
module lcds_queue import lcds_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_q_push,
    input  logic    i_take,
    output t_q_head o_q_head,
    output logic    o_full
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_entry          r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_wr, do_rd;

    assign o_full         = r_count == CW'(Q_DEPTH);
    assign o_q_head.valid = r_count != '0;
    assign o_q_head.entry = r_mem[r_rd_ptr];

    assign do_wr = i_q_push.push;
    assign do_rd = i_take && o_q_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_q_push.entry;
        end
    end

endmodule

>>> sv/lcds_back.sv
// back part: symbol sequencer and output register
module lcds_back import lcds_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_head    i_q_head,
    output logic       o_take,
    input  logic [2:0] i_brightness_level,
    input  logic       i_display_enable,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [1:0] o_symbol_kind,
    output logic       o_bit_level,
    output logic       o_run_last
);

`include "led_clock_digit_serial_sender_top_assert.svh"

    logic       r_busy, n_busy;
    logic [5:0] r_step, n_step;
    t_entry     r_entry;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic       r_level;
    logic       r_last;

    logic       load, last_load;
    logic [1:0] s_kind;
    logic       s_level;
    logic [7:0] s_byte;
    logic [5:0] s_off;

    assign load      = r_busy && (!r_out_valid || i_pop);
    assign last_load = load && (r_step == STEP_LAST);
    assign o_take    = i_q_head.valid && (!r_busy || last_load);

    // symbol for the current step
    always_comb begin
        s_byte = CMD_ADDR_FIXED;
        s_off  = r_step - B_ADDR;
        priority if (r_step < F1_ACK) begin
            s_byte = CMD_ADDR_FIXED;
            s_off  = r_step - B_ADDR;
        end else if (r_step < F2_ACK1) begin
            s_byte = CMD_CELL_BASE | {6'b0, r_entry.slot};
            s_off  = r_step - B_CELL;
        end else if (r_step < F2_ACK2) begin
            s_byte = r_entry.seg;
            s_off  = r_step - B_SEG;
        end else begin
            s_byte = {CMD_CTL_HIGH, i_display_enable, i_brightness_level};
            s_off  = r_step - B_CTL;
        end

        s_kind  = SYM_BIT;
        s_level = s_byte[s_off[2:0]];
        priority if (r_step == F1_START || r_step == F2_START || r_step == F3_START) begin
            s_kind  = SYM_START;
            s_level = 1'b1;
        end else if (r_step == F1_STOP || r_step == F2_STOP || r_step == STEP_LAST) begin
            s_kind  = SYM_STOP;
            s_level = 1'b1;
        end else if (r_step == F1_ACK || r_step == F2_ACK1 || r_step == F2_ACK2
                     || r_step == F3_ACK) begin
            s_kind  = SYM_ACK;
            s_level = 1'b1;
        end else begin
            s_kind  = SYM_BIT;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (o_take) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (last_load) begin
            n_busy = 1'b0;
        end else if (load) begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_entry <= i_q_head.entry;
        end
        if (load) begin
            r_kind  <= s_kind;
            r_level <= s_level;
            r_last  <= r_step == STEP_LAST;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_symbol_kind = r_kind;
    assign o_bit_level   = r_level;
    assign o_run_last    = r_last;

    `LCDS_ASSERT_IMP(a_step_bound, r_busy, r_step <= STEP_LAST, "step past end of run")
    `LCDS_ASSERT_IMP(a_last_is_stop, r_out_valid && r_last, r_kind == SYM_STOP,
        "run end not on a stop symbol")
    `LCDS_ASSERT_NXT(a_step_holds, r_busy && !load && !o_take, $stable(r_step),
        "step moved while output stalled")
    `LCDS_ASSERT_NXT(a_take_starts, o_take, r_busy && r_step == '0,
        "new request did not start at step zero")

endmodule

>>> sv/led_clock_digit_serial_sender_top.sv
// top level of the led clock digit sender: config registers, front, queue, back
// path: the first bus symbol of a request passes the queue, the sequencer step register and the output register
// throughput: one symbol a cycle from the back sequencer while pop keeps draining the output register, 42 per request
// the queue holds two classified requests; full rises while both wait behind a running one
// a request whose cell is at or above CELL_COUNT is dropped and gives no symbols
// reset is synchronous, active low: queue and sequencer empty, brightness 7, display on
module led_clock_digit_serial_sender_top import lcds_pkg::*; #(
    parameter int CELL_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [2:0] i_cfg_data,
    // request side
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_cell_index,
    input  logic [4:0] i_hour_value,
    input  logic [5:0] i_minute_value,
    input  logic       i_colon_on,
    // symbol side
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_symbol_kind,
    output logic       o_bit_level,
    output logic       o_run_last
);

    // configuration registers, read live by the back (the user must write them only while idle; not enforced)
    logic [2:0] r_brightness_level;
    logic       r_display_enable;

    t_q_push    q_push;
    t_q_head    q_head;
    logic       take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness_level <= 3'd7;
            r_display_enable   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BRIGHTNESS: r_brightness_level <= i_cfg_data;
                CFG_ENABLE:     r_display_enable   <= i_cfg_data[0];
                default:        r_display_enable   <= r_display_enable;
            endcase
        end
    end

    // front: range check, digit pick, segment pattern
    lcds_front #(
        .CELL_COUNT (CELL_COUNT)
    ) u_front (
        .i_push         (push),
        .i_full         (full),
        .i_cell_index   (i_cell_index),
        .i_hour_value   (i_hour_value),
        .i_minute_value (i_minute_value),
        .i_colon_on     (i_colon_on),
        .o_q_push       (q_push)
    );

    // short queue so request intake and symbol output stall apart
    lcds_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_push (q_push),
        .i_take   (take),
        .o_q_head (q_head),
        .o_full   (full)
    );

    // back: 42-step sequencer feeding the output register
    lcds_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_head           (q_head),
        .o_take             (take),
        .i_brightness_level (r_brightness_level),
        .i_display_enable   (r_display_enable),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_symbol_kind      (o_symbol_kind),
        .o_bit_level        (o_bit_level),
        .o_run_last         (o_run_last)
    );

endmodule

>>> tb/lcds_bus_checker.sv
// checker for the led clock digit sender: predicts the bus symbols of each request and compares
module lcds_bus_checker import lcds_pkg::*; #(
    parameter int CELL_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [2:0] i_cfg_data,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_cell_index,
    input  logic [4:0] i_hour_value,
    input  logic [5:0] i_minute_value,
    input  logic       i_colon_on,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [1:0] i_symbol_kind,
    input  logic       i_bit_level,
    input  logic       i_run_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [1:0] kind;
        logic       level;
        logic       last;
    } t_bus_symbol;

    t_bus_symbol symbols_due[$];
    t_bus_symbol head;
    t_bus_symbol tail;
    logic [2:0]  brightness = 3'd7;
    logic        display_on = 1'b1;
    int          symbols_seen = 0;
    int          fail_count = 0;
    int          pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic logic [6:0] digit_pattern(input int digit);
        case (digit)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            default: return 7'h6F;
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (fail_count < PRINT_CAP) begin
            $display("error: %s", msg);
        end
        fail_count++;
    endtask

    task automatic add_symbol(input logic [1:0] kind, input logic level);
        t_bus_symbol sym;
        sym.kind  = kind;
        sym.level = level;
        sym.last  = 1'b0;
        symbols_due.push_back(sym);
    endtask

    // eight data bits lsb first, then the ack clock slot
    task automatic add_byte(input logic [7:0] value);
        for (int i = 0; i < 8; i++) begin
            add_symbol(SYM_BIT, value[i]);
        end
        add_symbol(SYM_ACK, 1'b1);
    endtask

    task automatic queue_digit_write(input logic [1:0] slot, input logic [4:0] hours,
                                     input logic [5:0] minutes, input logic colon);
        int         digit;
        logic [7:0] segs;
        if (slot < CELL_COUNT) begin
            case (slot)
                2'd0:    digit = hours / 10;
                2'd1:    digit = hours % 10;
                2'd2:    digit = minutes / 10;
                default: digit = minutes % 10;
            endcase
            if (digit > 9) begin
                digit = 9;
            end
            segs = {colon, digit_pattern(digit)};
            add_symbol(SYM_START, 1'b1);
            add_byte(CMD_ADDR_FIXED);
            add_symbol(SYM_STOP, 1'b1);
            add_symbol(SYM_START, 1'b1);
            add_byte(CMD_CELL_BASE | {6'd0, slot});
            add_byte(segs);
            add_symbol(SYM_STOP, 1'b1);
            add_symbol(SYM_START, 1'b1);
            add_byte({CMD_CTL_HIGH, display_on, brightness});
            tail.kind  = SYM_STOP;
            tail.level = 1'b1;
            tail.last  = 1'b1;
            symbols_due.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            brightness = 3'd7;
            display_on = 1'b1;
            symbols_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BRIGHTNESS) begin
                    brightness = i_cfg_data;
                end else begin
                    display_on = i_cfg_data[0];
                end
            end
            if (i_push && !i_full) begin
                queue_digit_write(i_cell_index, i_hour_value, i_minute_value, i_colon_on);
            end
            if (i_pop && !i_empty) begin
                if (symbols_due.size() == 0) begin
                    report_error($sformatf("symbol %0d arrived with none expected",
                                           symbols_seen));
                end else begin
                    head = symbols_due.pop_front();
                    if (i_symbol_kind !== head.kind) begin
                        report_error($sformatf("symbol %0d kind: expected %0d, got %0d",
                                               symbols_seen, head.kind, i_symbol_kind));
                    end
                    if (i_bit_level !== head.level) begin
                        report_error($sformatf("symbol %0d level: expected %0d, got %0d",
                                               symbols_seen, head.level, i_bit_level));
                    end
                    if (i_run_last !== head.last) begin
                        report_error($sformatf("symbol %0d last: expected %0d, got %0d",
                                               symbols_seen, head.last, i_run_last));
                    end
                end
                symbols_seen++;
            end
        end
        pending = symbols_due.size();
    end

endmodule

>>> tb/tb_led_clock_digit_serial_sender_top.sv
// testbench top for the led clock digit sender: clock, reset, stimulus and verdict
module tb_led_clock_digit_serial_sender_top;
    import lcds_pkg::*;

    localparam int CELLS           = 4;
    localparam int ITEMS_PER_PHASE = 24;
    localparam int PHASES          = 5;
    // idle cycles given to the block once every expected symbol has drained
    localparam int SETTLE_CYCLES   = 8;
    // far beyond the longest send gap or receive stall
    localparam int WATCHDOG_LIMIT  = 2000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [2:0] i_cfg_data;
    logic       push;
    logic       full;
    logic [1:0] i_cell_index;
    logic [4:0] i_hour_value;
    logic [5:0] i_minute_value;
    logic       i_colon_on;
    logic       empty;
    logic       pop;
    logic [1:0] o_symbol_kind;
    logic       o_bit_level;
    logic       o_run_last;

    int         fail_count;
    int         pending;
    int         pop_hold;
    int         quiet_cycles;
    bit         calm;

    led_clock_digit_serial_sender_top #(
        .CELL_COUNT(CELLS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_cell_index   (i_cell_index),
        .i_hour_value   (i_hour_value),
        .i_minute_value (i_minute_value),
        .i_colon_on     (i_colon_on),
        .empty          (empty),
        .pop            (pop),
        .o_symbol_kind  (o_symbol_kind),
        .o_bit_level    (o_bit_level),
        .o_run_last     (o_run_last)
    );

    // predicts the 42 symbols of each in-range request and compares what pops out
    lcds_bus_checker #(
        .CELL_COUNT(CELLS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_full         (full),
        .i_cell_index   (i_cell_index),
        .i_hour_value   (i_hour_value),
        .i_minute_value (i_minute_value),
        .i_colon_on     (i_colon_on),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_symbol_kind  (o_symbol_kind),
        .i_bit_level    (o_bit_level),
        .i_run_last     (o_run_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 2 time unit clock period
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // gap before a request: mostly none, some short, a few long
    function automatic int push_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // receiver stall length: mostly short, now and then long
    function automatic int stall_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 80);
    endfunction

    // receiver side: pop stays high except during random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_hold = 0;
        end else if (pop_hold > 0) begin
            pop_hold = pop_hold - 1;
            pop      <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 15) begin
            // this cycle is the first of the stall
            pop_hold = stall_length() - 1;
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // watchdog: too long without any request or symbol moving means the block hung
    always @(posedge i_clk) begin
        if (i_rst_n && !((push && !full) || (pop && !empty))) begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // hold one request on the ports until it is taken
    // push stays high into the next request when no gap follows
    task automatic send_request(input logic [1:0] slot, input logic [4:0] hours,
                                input logic [5:0] minutes, input logic colon);
        int gap;
        gap = calm ? 0 : push_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_cell_index   <= slot;
        i_hour_value   <= hours;
        i_minute_value <= minutes;
        i_colon_on     <= colon;
        do @(posedge i_clk); while (full);
    endtask

    // mostly legal clock values, with some out-of-range ones that still fit the fields
    task automatic send_random_request();
        logic [1:0] slot;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic       colon;
        slot = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 8) begin
            hours = 5'($urandom_range(0, 23));
        end else begin
            hours = 5'($urandom_range(24, 31));
        end
        if ($urandom_range(0, 9) < 8) begin
            minutes = 6'($urandom_range(0, 59));
        end else begin
            minutes = 6'($urandom_range(60, 63));
        end
        colon = 1'($urandom_range(0, 1));
        send_request(slot, hours, minutes, colon);
    endtask

    // stop requesting, let every expected symbol drain, then give the block a few cycles
    task automatic settle();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // brightness first, then enable; spare data bits of the enable write are random
    task automatic write_config(input logic [2:0] level, input logic on);
        logic [1:0] spare;
        spare = 2'($urandom_range(0, 3));
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BRIGHTNESS;
        i_cfg_data <= level;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ENABLE;
        i_cfg_data <= {spare, on};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_BRIGHTNESS;
        i_cfg_data     = 3'd0;
        push           = 1'b0;
        i_cell_index   = 2'd0;
        i_hour_value   = 5'd0;
        i_minute_value = 6'd0;
        i_colon_on     = 1'b0;
        calm           = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset settings
        // every digit once: even ones on the hour units cell, odd ones on the minute units cell
        for (int d = 0; d < 10; d++) begin
            send_request(d[0] ? 2'd3 : 2'd1, 5'(d), 6'(50 + d), d[0]);
        end
        // digit six again, on minutes with the colon
        send_request(2'd3, 5'd0, 6'd56, 1'b1);
        // largest field values: out-of-range hours and minutes still give digits
        send_request(2'd0, 5'd31, 6'd63, 1'b1);
        send_request(2'd1, 5'd31, 6'd0, 1'b1);
        send_request(2'd2, 5'd0, 6'd63, 1'b0);
        // all-zero requests, legal maximum minutes on the minute tens cell and 63 on the minute units cell
        send_request(2'd0, 5'd0, 6'd0, 1'b0);
        send_request(2'd2, 5'd23, 6'd59, 1'b1);
        send_request(2'd3, 5'd23, 6'd63, 1'b1);
        send_request(2'd3, 5'd0, 6'd0, 1'b0);

        // random phases, each under its own display settings
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0:       write_config(3'd0, 1'b0);
                1:       write_config(3'd7, 1'b0);
                2:       write_config(3'd0, 1'b1);
                3:       write_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                default: write_config(3'd7, 1'b1);
            endcase
            // one phase runs back to back with no idling on either side
            calm = (p == 2);
            repeat (ITEMS_PER_PHASE) send_random_request();
        end
        calm = 1'b0;
        settle();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
